// File: rtl/bta_pkg.sv
package bta_pkg;

  localparam int unsigned MAX_STEPS  = 1024;
  localparam int unsigned NODE_DEPTH = MAX_STEPS + 1;
  localparam int unsigned NODE_W     = $clog2(NODE_DEPTH);

  localparam int unsigned PRICE_W    = 32;
  localparam int unsigned FACTOR_W   = 32;
  localparam int unsigned DEPTH_W    = 11;
  localparam int unsigned FRAC_SH    = 30;
  localparam int unsigned PROD_W     = PRICE_W + FACTOR_W;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UP_SQ     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UP_WGT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DN_WGT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM    = 3'd6;

  localparam logic [PRICE_W-1:0]  RST_STRIKE = 32'd0;
  localparam logic [DEPTH_W-1:0]  RST_DEPTH  = 11'd1;
  localparam logic [FACTOR_W-1:0] RST_UNITY  = 32'h4000_0000;
  localparam logic [FACTOR_W-1:0] RST_HALF   = 32'h2000_0000;

  typedef struct packed {
    logic [PRICE_W-1:0]  strike_price;
    logic [DEPTH_W-1:0]  tree_depth;
    logic [FACTOR_W-1:0] up_factor;
    logic [FACTOR_W-1:0] up_factor_squared;
    logic [FACTOR_W-1:0] discounted_up_weight;
    logic [FACTOR_W-1:0] discounted_down_weight;
    logic [FACTOR_W-1:0] bottom_node_factor;
  } bta_cfg_t;

  // One node issued into the continuation pipe
  typedef struct packed {
    logic               valid;
    logic [NODE_W-1:0]  node;
    logic [PRICE_W-1:0] price;
  } bta_iss_t;

  // Node memory write request
  typedef struct packed {
    logic               en;
    logic [NODE_W-1:0]  addr;
    logic [PRICE_W-1:0] data;
  } bta_wr_t;

  function automatic logic [PRICE_W-1:0] intrinsic(input logic [PRICE_W-1:0] strike,
                                                   input logic [PRICE_W-1:0] price);
    return (strike > price) ? (strike - price) : '0;
  endfunction

endpackage

// File: rtl/binomial_tree_american_put_core.sv
// channel | valid      | stall      | payload
// --------+------------+------------+----------------------------------
// input   | in_valid_i | in_stall_o | spot_price_i   (Q16.16)
// output  | out_valid_o| out_stall_i| option_value_o (Q16.16, sat)
// config  | cfg_we_i   | -          | cfg_idx_i, cfg_wdata_i
//
// After an item is accepted, with N = depth clamped to 1024, the run steps through a seed
// state, the N+1 terminal nodes, and per level a start state, the nodes of that level in
// turn and a drain state; a done state then loads the result and raises out_valid_o.
// Reset is asynchronous, active low; node memory is not cleared.
// in_stall_o is high while a run is in progress; a finished result waits
// in the output register, and a new item can be accepted meanwhile.
module binomial_tree_american_put_core import bta_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PRICE_W-1:0]    spot_price_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PRICE_W-1:0]    option_value_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEED   = 3'd1;
  localparam logic [2:0] ST_TERM   = 3'd2;
  localparam logic [2:0] ST_LSTART = 3'd3;
  localparam logic [2:0] ST_LEVEL  = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  function automatic logic [PRICE_W-1:0] scale_price(input logic [PRICE_W-1:0]  p,
                                                     input logic [FACTOR_W-1:0] f);
    logic [PROD_W-1:0]         prod;
    logic [PROD_W:0]           sum;
    logic [PROD_W-FRAC_SH:0]   quo;
    prod = {{FACTOR_W{1'b0}}, p} * {{PRICE_W{1'b0}}, f};
    sum  = {1'b0, prod} + ((PROD_W + 1)'(1) << (FRAC_SH - 1));
    quo  = sum[PROD_W:FRAC_SH];
    return (|quo[PROD_W-FRAC_SH:PRICE_W]) ? '1 : quo[PRICE_W-1:0];
  endfunction

  bta_cfg_t           cfg;
  bta_iss_t           iss_d, iss_q;
  bta_wr_t            pipe_wr, mem_wr;
  logic [NODE_W-1:0]  rd_addr;
  logic [PRICE_W-1:0] rd_data;

  logic [2:0]         state_d, state_q;
  logic [NODE_W-1:0]  node_d, node_q;
  logic [NODE_W-1:0]  level_d, level_q;
  logic [NODE_W-1:0]  depth_d, depth_q;
  logic               drain_d, drain_q;
  logic [PRICE_W-1:0] price_d, price_q;
  logic [PRICE_W-1:0] lstart_d, lstart_q;
  logic [PRICE_W-1:0] spot_q;
  logic [PRICE_W-1:0] root_q;
  logic               out_valid_d, out_valid_q;
  logic [PRICE_W-1:0] option_value_q;

  logic [PRICE_W-1:0]  mul_a, scaled;
  logic [FACTOR_W-1:0] mul_b;
  logic                in_accept, out_load;

  bta_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bta_node_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bta_cont_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .strike_i    (cfg.strike_price),
    .up_weight_i (cfg.discounted_up_weight),
    .dn_weight_i (cfg.discounted_down_weight),
    .iss_i       (iss_q),
    .rd_data_i   (rd_data),
    .wr_o        (pipe_wr)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Shared price multiplier
  always_comb begin
    case (state_q)
      ST_SEED: begin
        mul_a = spot_q;
        mul_b = cfg.bottom_node_factor;
      end
      ST_LSTART: begin
        mul_a = lstart_q;
        mul_b = cfg.up_factor;
      end
      default: begin
        mul_a = price_q;
        mul_b = cfg.up_factor_squared;
      end
    endcase
    scaled = scale_price(mul_a, mul_b);
  end

  // Terminal level writes directly; induction writes come from the pipe
  always_comb begin
    if (state_q == ST_TERM) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = node_q;
      mem_wr.data = intrinsic(cfg.strike_price, price_q);
    end else begin
      mem_wr = pipe_wr;
    end
  end

  always_comb begin
    state_d  = state_q;
    node_d   = node_q;
    level_d  = level_q;
    depth_d  = depth_q;
    drain_d  = drain_q;
    price_d  = price_q;
    lstart_d = lstart_q;
    rd_addr  = '0;
    iss_d.valid = 1'b0;
    iss_d.node  = node_q;
    iss_d.price = price_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          depth_d = (32'(cfg.tree_depth) > 32'(MAX_STEPS)) ? NODE_W'(MAX_STEPS)
                                                          : NODE_W'(cfg.tree_depth);
          state_d = ST_SEED;
        end
      end
      ST_SEED: begin
        lstart_d = scaled;
        price_d  = scaled;
        node_d   = '0;
        state_d  = ST_TERM;
      end
      ST_TERM: begin
        price_d = scaled;
        if (node_q == depth_q) begin
          if (depth_q == '0) begin
            state_d = ST_DONE;
          end else begin
            level_d = depth_q - NODE_W'(1);
            state_d = ST_LSTART;
          end
        end else begin
          node_d = node_q + NODE_W'(1);
        end
      end
      ST_LSTART: begin
        // fetch V[0] ahead of the first node
        lstart_d = scaled;
        price_d  = scaled;
        node_d   = '0;
        rd_addr  = '0;
        state_d  = ST_LEVEL;
      end
      ST_LEVEL: begin
        rd_addr     = node_q + NODE_W'(1);
        iss_d.valid = 1'b1;
        price_d     = scaled;
        if (node_q == level_q) begin
          drain_d = 1'b0;
          state_d = ST_DRAIN;
        end else begin
          node_d = node_q + NODE_W'(1);
        end
      end
      ST_DRAIN: begin
        // let the last writes of this level land before reading it again
        if (drain_q) begin
          if (level_q == '0) begin
            state_d = ST_DONE;
          end else begin
            level_d = level_q - NODE_W'(1);
            state_d = ST_LSTART;
          end
        end else begin
          drain_d = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      node_q      <= '0;
      level_q     <= '0;
      depth_q     <= '0;
      drain_q     <= 1'b0;
      price_q     <= '0;
      lstart_q    <= '0;
      iss_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      node_q      <= node_d;
      level_q     <= level_d;
      depth_q     <= depth_d;
      drain_q     <= drain_d;
      price_q     <= price_d;
      lstart_q    <= lstart_d;
      iss_q       <= iss_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      spot_q <= spot_price_i;
    end
    // track the root entry as it is written
    if (mem_wr.en && (mem_wr.addr == '0)) begin
      root_q <= mem_wr.data;
    end
    if (out_load) begin
      option_value_q <= root_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign option_value_o = option_value_q;

`ifndef SYNTHESIS
  a_wr_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr.en |-> (state_q == ST_TERM || state_q == ST_LEVEL || state_q == ST_DRAIN))
    else $error("node write outside a pricing run");

  a_pipe_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_wr.en |-> (pipe_wr.addr <= level_q))
    else $error("induction write beyond current level");

  a_node_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEVEL) |-> (node_q <= level_q && level_q < depth_q))
    else $error("node or level index out of range");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result raised outside completion");
`endif

endmodule

// File: rtl/bta_cfg_regs.sv
module bta_cfg_regs import bta_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output bta_cfg_t              cfg_o
);

  bta_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STRIKE: cfg_d.strike_price           = cfg_wdata_i[PRICE_W-1:0];
        REG_DEPTH:  cfg_d.tree_depth             = cfg_wdata_i[DEPTH_W-1:0];
        REG_UP:     cfg_d.up_factor              = cfg_wdata_i[FACTOR_W-1:0];
        REG_UP_SQ:  cfg_d.up_factor_squared      = cfg_wdata_i[FACTOR_W-1:0];
        REG_UP_WGT: cfg_d.discounted_up_weight   = cfg_wdata_i[FACTOR_W-1:0];
        REG_DN_WGT: cfg_d.discounted_down_weight = cfg_wdata_i[FACTOR_W-1:0];
        REG_BOTTOM: cfg_d.bottom_node_factor     = cfg_wdata_i[FACTOR_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strike_price           <= RST_STRIKE;
      cfg_q.tree_depth             <= RST_DEPTH;
      cfg_q.up_factor              <= RST_UNITY;
      cfg_q.up_factor_squared      <= RST_UNITY;
      cfg_q.discounted_up_weight   <= RST_HALF;
      cfg_q.discounted_down_weight <= RST_HALF;
      cfg_q.bottom_node_factor     <= RST_UNITY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/bta_node_mem.sv
module bta_node_mem import bta_pkg::*; (
  input  logic               clk_i,
  input  bta_wr_t            wr_i,
  input  logic [NODE_W-1:0]  rd_addr_i,
  output logic [PRICE_W-1:0] rd_data_o
);

  logic [PRICE_W-1:0] mem [NODE_DEPTH];
  logic [PRICE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/bta_cont_pipe.sv
module bta_cont_pipe import bta_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [PRICE_W-1:0]  strike_i,
  input  logic [FACTOR_W-1:0] up_weight_i,
  input  logic [FACTOR_W-1:0] dn_weight_i,
  input  bta_iss_t            iss_i,
  input  logic [PRICE_W-1:0]  rd_data_i,
  output bta_wr_t             wr_o
);

  localparam int unsigned SUM_W = PROD_W + 2;
  localparam int unsigned QUO_W = SUM_W - FRAC_SH;

  logic [PRICE_W-1:0] rd_prev_q;
  logic               s1_valid_q;
  logic [NODE_W-1:0]  s1_node_q;
  logic [PRICE_W-1:0] s1_price_q;
  logic [PROD_W-1:0]  p_up_q, p_dn_q;

  logic [SUM_W-1:0]   sum;
  logic [QUO_W-1:0]   quo;
  logic [PRICE_W-1:0] cont, ex;

  // rd_data holds V[j+1]; the word read before it, held in rd_prev_q, is V[j]
  always_ff @(posedge clk_i) begin
    rd_prev_q  <= rd_data_i;
    s1_node_q  <= iss_i.node;
    s1_price_q <= iss_i.price;
    p_up_q     <= {{PRICE_W{1'b0}}, up_weight_i} * {{FACTOR_W{1'b0}}, rd_data_i};
    p_dn_q     <= {{PRICE_W{1'b0}}, dn_weight_i} * {{FACTOR_W{1'b0}}, rd_prev_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= iss_i.valid;
    end
  end

  // Exact sum of both products, round to nearest, saturate
  always_comb begin
    sum  = {2'b00, p_up_q} + {2'b00, p_dn_q} + (SUM_W'(1) << (FRAC_SH - 1));
    quo  = sum[SUM_W-1:FRAC_SH];
    cont = (|quo[QUO_W-1:PRICE_W]) ? '1 : quo[PRICE_W-1:0];
    ex   = intrinsic(strike_i, s1_price_q);
  end

  assign wr_o.en   = s1_valid_q;
  assign wr_o.addr = s1_node_q;
  assign wr_o.data = (ex > cont) ? ex : cont;

endmodule
